/* hdl/lsre_pkg.sv */
// ----------------------------------------------------------------------------
// lsre_pkg
// Shared types and register codes for the logic sample run-length expander.
// ----------------------------------------------------------------------------
package lsre_pkg;

  // Width of the configuration data bus (widest register).
  localparam int unsigned CFG_DATA_BITS = 32;

  // Results one chunk can cause: a run of the held sample plus two samples.
  localparam int unsigned RESULTS_MAX = 3;

  // Configuration register indexes.
  typedef enum logic [0:0] {
    REG_LIMIT_ENABLE = 1'b0,
    REG_SAMPLE_LIMIT = 1'b1
  } cfg_reg_e;

  // One configuration write.
  typedef struct packed {
    logic                     we;
    cfg_reg_e                 index;
    logic [CFG_DATA_BITS-1:0] wdata;
  } cfg_wr_t;

endpackage

/* hdl/lsre_chunk_asm.sv */
// ----------------------------------------------------------------------------
// lsre_chunk_asm
// Gathers raw bytes into little-endian chunks of stamp, first and second
// sample, and holds a completed chunk until the run stage takes it.
// ----------------------------------------------------------------------------
module lsre_chunk_asm #(
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [7:0]             data_byte_i,
  input  logic                   chunk_take_i,
  output logic                   chunk_valid_o,
  output logic [SAMPLE_BITS-1:0] stamp_o,
  output logic [SAMPLE_BITS-1:0] first_o,
  output logic [SAMPLE_BITS-1:0] second_o
);
  import lsre_pkg::*;

  localparam int unsigned WordBytes  = (SAMPLE_BITS + 7) / 8;
  localparam int unsigned ChunkBytes = 3 * WordBytes;
  localparam int unsigned PartBits   = (ChunkBytes - 1) * 8;
  localparam int unsigned PosBits    = $clog2(ChunkBytes);
  localparam logic [PosBits-1:0] PosLast = PosBits'(ChunkBytes - 1);

  logic [PosBits-1:0]         pos_q, pos_d;
  logic [PartBits-1:0]        part_q, part_d;
  logic [ChunkBytes*8-1:0]    full;
  logic                       chunk_vld_q, chunk_vld_d;
  logic [SAMPLE_BITS-1:0]     stamp_q, first_q, second_q;
  logic                       last_byte, in_fire;

  assign last_byte  = (pos_q == PosLast);
  assign in_ready_o = !last_byte || !chunk_vld_q || chunk_take_i;
  assign in_fire    = in_valid_i && in_ready_o;
  assign full       = {data_byte_i, part_q};

  always_comb begin
    pos_d       = pos_q;
    part_d      = part_q;
    chunk_vld_d = chunk_vld_q && !chunk_take_i;
    if (in_fire) begin
      if (last_byte) begin
        pos_d       = '0;
        chunk_vld_d = 1'b1;
      end else begin
        pos_d = pos_q + PosBits'(1);
      end
      // shift in from the top so the oldest byte lands at the bottom
      if (PartBits > 8) begin
        part_d = {data_byte_i, part_q[PartBits-1:8]};
      end else begin
        part_d = PartBits'(data_byte_i);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      chunk_vld_q <= 1'b0;
    end else begin
      pos_q       <= pos_d;
      chunk_vld_q <= chunk_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    part_q <= part_d;
    if (in_fire && last_byte) begin
      stamp_q  <= full[0 +: SAMPLE_BITS];
      first_q  <= full[WordBytes*8 +: SAMPLE_BITS];
      second_q <= full[2*WordBytes*8 +: SAMPLE_BITS];
    end
  end

  assign chunk_valid_o = chunk_vld_q;
  assign stamp_o       = stamp_q;
  assign first_o       = first_q;
  assign second_o      = second_q;

endmodule

/* hdl/lsre_run_calc.sv */
// ----------------------------------------------------------------------------
// lsre_run_calc
// Turns one chunk into up to three results, applies the sample limit and
// keeps the held sample, priming and stop state.
// ----------------------------------------------------------------------------
module lsre_run_calc #(
  parameter int unsigned SAMPLE_BITS = 16,
  parameter int unsigned LIMIT_BITS  = 32
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  lsre_pkg::cfg_wr_t                          cfg_i,
  input  logic                                       chunk_valid_i,
  output logic                                       chunk_take_o,
  input  logic [SAMPLE_BITS-1:0]                     stamp_i,
  input  logic [SAMPLE_BITS-1:0]                     first_i,
  input  logic [SAMPLE_BITS-1:0]                     second_i,
  input  logic                                       buf_free_i,
  output logic                                       load_o,
  output logic [lsre_pkg::RESULTS_MAX-1:0]           mask_o,
  output logic [lsre_pkg::RESULTS_MAX-1:0][SAMPLE_BITS-1:0] value_o,
  output logic [lsre_pkg::RESULTS_MAX-1:0][SAMPLE_BITS:0]   count_o,
  output logic [lsre_pkg::RESULTS_MAX-1:0]           last_o,
  output logic [lsre_pkg::RESULTS_MAX-1:0]           hit_o
);
  import lsre_pkg::*;

  localparam int unsigned CntBits = SAMPLE_BITS + 1;
  localparam int unsigned AriBits = ((LIMIT_BITS > CntBits) ? LIMIT_BITS : CntBits) + 1;

  logic                   limit_en_q;
  logic [LIMIT_BITS-1:0]  rem_q, rem_d;
  logic [SAMPLE_BITS-1:0] held_q;
  logic                   primed_q, stopped_q, stopped_d;

  logic [SAMPLE_BITS-1:0] stamp_dec;
  logic [CntBits-1:0]     want, run_cnt;
  logic [AriBits-1:0]     want_a, rem_a, diff;
  logic                   rem_gt;
  logic [LIMIT_BITS-1:0]  r1;
  logic [RESULTS_MAX-1:0] vld, hit;
  logic                   go;

  assign go           = chunk_valid_i && buf_free_i;
  assign chunk_take_o = go;
  assign load_o       = go;

  always_comb begin
    stamp_dec = (stamp_i == '0) ? '0 : stamp_i - SAMPLE_BITS'(1);
    want      = {stamp_dec, 1'b0};
    want_a    = AriBits'(want);
    rem_a     = AriBits'(rem_q);
    rem_gt    = rem_a > want_a;
    diff      = rem_a - want_a;
    r1        = rem_gt ? diff[LIMIT_BITS-1:0] : '0;
    rem_d     = rem_q;
    stopped_d = 1'b0;
    if (limit_en_q) begin
      run_cnt   = rem_gt ? want : rem_a[CntBits-1:0];
      vld[0]    = (run_cnt != '0);
      hit[0]    = (r1 == '0);
      vld[1]    = (r1 != '0);
      hit[1]    = (r1 == LIMIT_BITS'(1));
      vld[2]    = (r1 > LIMIT_BITS'(1));
      hit[2]    = (r1 == LIMIT_BITS'(2));
      stopped_d = (r1 < LIMIT_BITS'(3));
      rem_d     = stopped_d ? '0 : r1 - LIMIT_BITS'(2);
    end else begin
      run_cnt = want;
      vld     = {2'b11, (want != '0)};
      hit     = '0;
    end
  end

  always_comb begin
    mask_o     = (primed_q && !stopped_q) ? vld : '0;
    hit_o      = hit;
    value_o[0] = held_q;
    value_o[1] = first_i;
    value_o[2] = second_i;
    count_o[0] = run_cnt;
    count_o[1] = CntBits'(1);
    count_o[2] = CntBits'(1);
    last_o[2]  = vld[2];
    last_o[1]  = vld[1] && !vld[2];
    last_o[0]  = vld[0] && !vld[1] && !vld[2];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_en_q <= 1'b0;
      rem_q      <= '0;
      held_q     <= '0;
      primed_q   <= 1'b0;
      stopped_q  <= 1'b0;
    end else begin
      if (go && !stopped_q) begin
        held_q   <= second_i;
        primed_q <= 1'b1;
        if (primed_q) begin
          rem_q     <= rem_d;
          stopped_q <= stopped_d;
        end
      end
      if (cfg_i.we) begin
        case (cfg_i.index)
          REG_LIMIT_ENABLE: limit_en_q <= cfg_i.wdata[0];
          REG_SAMPLE_LIMIT: rem_q      <= LIMIT_BITS'(cfg_i.wdata);
          default:          ;
        endcase
      end
    end
  end

endmodule

/* hdl/lsre_out_buf.sv */
// ----------------------------------------------------------------------------
// lsre_out_buf
// Three-entry result buffer; hands out a chunk's results in order, one per
// output transaction.
// ----------------------------------------------------------------------------
module lsre_out_buf #(
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  logic                                       load_i,
  input  logic [lsre_pkg::RESULTS_MAX-1:0]           mask_i,
  input  logic [lsre_pkg::RESULTS_MAX-1:0][SAMPLE_BITS-1:0] value_i,
  input  logic [lsre_pkg::RESULTS_MAX-1:0][SAMPLE_BITS:0]   count_i,
  input  logic [lsre_pkg::RESULTS_MAX-1:0]           last_i,
  input  logic [lsre_pkg::RESULTS_MAX-1:0]           hit_i,
  output logic                                       free_o,
  output logic                                       out_valid_o,
  input  logic                                       out_ready_i,
  output logic [SAMPLE_BITS-1:0]                     sample_value_o,
  output logic [SAMPLE_BITS:0]                       repeat_count_o,
  output logic                                       run_last_o,
  output logic                                       limit_hit_o
);
  import lsre_pkg::*;

  logic [RESULTS_MAX-1:0]                  mask_q, mask_d, mask_left, sel;
  logic [RESULTS_MAX-1:0][SAMPLE_BITS-1:0] value_q;
  logic [RESULTS_MAX-1:0][SAMPLE_BITS:0]   count_q;
  logic [RESULTS_MAX-1:0]                  last_q, hit_q;
  logic                                    out_fire;

  // one-hot pick of the lowest pending entry
  assign sel         = mask_q & ~(mask_q - RESULTS_MAX'(1));
  assign out_valid_o = (mask_q != '0);
  assign out_fire    = out_valid_o && out_ready_i;

  always_comb begin
    sample_value_o = '0;
    repeat_count_o = '0;
    run_last_o     = 1'b0;
    limit_hit_o    = 1'b0;
    for (int i = 0; i < RESULTS_MAX; i++) begin
      if (sel[i]) begin
        sample_value_o = value_q[i];
        repeat_count_o = count_q[i];
        run_last_o     = last_q[i];
        limit_hit_o    = hit_q[i];
      end
    end
  end

  // entries still pending after this cycle's transaction
  assign mask_left = out_fire ? (mask_q & ~sel) : mask_q;
  assign free_o    = (mask_left == '0);

  always_comb begin
    mask_d = mask_left;
    if (load_i) begin
      mask_d = mask_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= '0;
    end else begin
      mask_q <= mask_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      value_q <= value_i;
      count_q <= count_i;
      last_q  <= last_i;
      hit_q   <= hit_i;
    end
  end

endmodule

/* hdl/logic_sample_rle_expander_top.sv */
// ----------------------------------------------------------------------------
// logic_sample_rle_expander_top
// Run-length expander for a captured logic sample stream.
// ----------------------------------------------------------------------------
// Takes one raw byte per input transaction and assembles chunks of three
// little-endian words (stamp in 10 ns units, first sample, second sample).
// The first chunk after reset only primes the held sample. Each later chunk
// yields up to three output transactions: a run of the held sample repeated
// 2*(stamp-1) times (stamp zero counts as one, run dropped when empty), then
// the first and the second sample once each; run_last marks the chunk's
// final result. With limit_enable set every count is capped by a remaining
// counter loaded by writing sample_limit; the result that empties it carries
// limit_hit, and from then on all input bytes are accepted and dropped until
// reset. Throughput is one byte per cycle while in_ready_o is high: a finished
// chunk is turned into results combinationally and parked in a three-entry
// result buffer that drains one result per cycle while out_ready_i is high,
// so a chunk's results leave during the next chunk's bytes. in_ready_o drops
// only while a completed chunk waits behind results the output side has not
// taken yet. A chunk is registered in the assembler, then its results in the
// result buffer. Write configuration only while the block is idle.
// ----------------------------------------------------------------------------
module logic_sample_rle_expander_top #(
  parameter int unsigned SAMPLE_BITS = 16,
  parameter int unsigned LIMIT_BITS  = 32
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // configuration write port
  input  logic                               cfg_we_i,
  input  logic [0:0]                         cfg_index_i,
  input  logic [lsre_pkg::CFG_DATA_BITS-1:0] cfg_wdata_i,
  // byte stream in
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [7:0]                         data_byte_i,
  // results out
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [SAMPLE_BITS-1:0]             sample_value_o,
  output logic [SAMPLE_BITS:0]               repeat_count_o,
  output logic                               run_last_o,
  output logic                               limit_hit_o
);
  import lsre_pkg::*;

  cfg_wr_t                                 cfg;
  logic                                    chunk_valid, chunk_take;
  logic [SAMPLE_BITS-1:0]                  stamp, first, second;
  logic                                    buf_free, buf_load;
  logic [RESULTS_MAX-1:0]                  res_mask, res_last, res_hit;
  logic [RESULTS_MAX-1:0][SAMPLE_BITS-1:0] res_value;
  logic [RESULTS_MAX-1:0][SAMPLE_BITS:0]   res_count;

  // bundle the write port for the run stage
  always_comb begin
    cfg.we    = cfg_we_i;
    cfg.index = cfg_reg_e'(cfg_index_i);
    cfg.wdata = cfg_wdata_i;
  end

  // gather bytes into a chunk and hold it for the run stage
  lsre_chunk_asm #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_chunk_asm (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .data_byte_i  (data_byte_i),
    .chunk_take_i (chunk_take),
    .chunk_valid_o(chunk_valid),
    .stamp_o      (stamp),
    .first_o      (first),
    .second_o     (second)
  );

  // expand the chunk, apply the limit, advance held sample and stop state
  lsre_run_calc #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .LIMIT_BITS (LIMIT_BITS)
  ) u_run_calc (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .chunk_valid_i(chunk_valid),
    .chunk_take_o (chunk_take),
    .stamp_i      (stamp),
    .first_i      (first),
    .second_i     (second),
    .buf_free_i   (buf_free),
    .load_o       (buf_load),
    .mask_o       (res_mask),
    .value_o      (res_value),
    .count_o      (res_count),
    .last_o       (res_last),
    .hit_o        (res_hit)
  );

  // hold results and hand them out one transaction at a time
  lsre_out_buf #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_out_buf (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (buf_load),
    .mask_i        (res_mask),
    .value_i       (res_value),
    .count_i       (res_count),
    .last_i        (res_last),
    .hit_i         (res_hit),
    .free_o        (buf_free),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .sample_value_o(sample_value_o),
    .repeat_count_o(repeat_count_o),
    .run_last_o    (run_last_o),
    .limit_hit_o   (limit_hit_o)
  );

endmodule

/* bench/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the logic sample run-length expander.
// ----------------------------------------------------------------------------
// Streams raw chunk bytes into the block and predicts every result transaction
// as each byte is accepted. Covers a short directed opening, random chunks
// with the limit on and off, a long receiver hold-off that backs up the
// input, and a limited final phase that runs the counter down to the stop.
// Both handshake sides idle at random between transactions.
// ----------------------------------------------------------------------------
module tb_top;
  import lsre_pkg::*;

  // One predicted or observed result transaction.
  typedef struct packed {
    logic [15:0] value;
    logic [16:0] count;
    logic        last;
    logic        hit;
  } sample_run_t;

  // Mirror of the expander: configuration, chunk assembly and the limit.
  class sample_run_scoreboard;
    bit          limit_on;
    bit   [31:0] remaining;
    bit   [2:0]  byte_pos;
    bit   [7:0]  chunk_bytes[6];
    bit   [15:0] held;
    bit          primed;
    bit          stopped;
    int unsigned errors;
    sample_run_t expected_runs[$];

    function void mirror_reg(cfg_reg_e idx, logic [31:0] value);
      if (idx == REG_LIMIT_ENABLE) begin
        limit_on = value[0];
      end else begin
        remaining = value;
      end
    endfunction

    function bit drained();
      return limit_on && remaining == 0;
    endfunction

    // Cap a count by the remaining samples and charge it.
    function bit [16:0] grant(bit [16:0] want);
      if (!limit_on) return want;
      if (want > remaining) want = remaining[16:0];
      remaining -= 32'(want);
      return want;
    endfunction

    function sample_run_t make_run(bit [15:0] value, bit [16:0] count);
      sample_run_t r;
      r.value = value;
      r.count = count;
      r.last  = 1'b0;
      r.hit   = drained();
      return r;
    endfunction

    // Fold one accepted byte in; a completed chunk queues its results.
    function void absorb_byte(logic [7:0] b);
      bit [15:0]   stamp, first, second;
      bit [16:0]   c;
      sample_run_t chunk_runs[$];
      if (stopped) return;
      chunk_bytes[byte_pos] = b;
      byte_pos++;
      if (byte_pos < 6) return;
      byte_pos = 0;
      stamp  = {chunk_bytes[1], chunk_bytes[0]};
      first  = {chunk_bytes[3], chunk_bytes[2]};
      second = {chunk_bytes[5], chunk_bytes[4]};
      if (!primed) begin
        primed = 1'b1;
        held   = second;
        return;
      end
      if (stamp != 0) stamp--;
      c = grant({stamp, 1'b0});
      if (c != 0) chunk_runs.push_back(make_run(held, c));
      if (drained()) begin
        stopped = 1'b1;
      end else begin
        if (grant(17'd1) != 0) chunk_runs.push_back(make_run(first, 17'd1));
        held = first;
        if (drained()) begin
          stopped = 1'b1;
        end else begin
          if (grant(17'd1) != 0) chunk_runs.push_back(make_run(second, 17'd1));
          held = second;
          if (drained()) stopped = 1'b1;
        end
      end
      if (chunk_runs.size() > 0) chunk_runs[chunk_runs.size()-1].last = 1'b1;
      foreach (chunk_runs[i]) expected_runs.push_back(chunk_runs[i]);
    endfunction

    function void check_run(sample_run_t got);
      sample_run_t exp_run;
      if (expected_runs.size() == 0) begin
        $error("unexpected result: sample_value %h repeat_count %0d", got.value, got.count);
        errors++;
        return;
      end
      exp_run = expected_runs.pop_front();
      if (got.value !== exp_run.value) begin
        $error("sample_value: expected %h, got %h", exp_run.value, got.value);
        errors++;
      end
      if (got.count !== exp_run.count) begin
        $error("repeat_count: expected %0d, got %0d", exp_run.count, got.count);
        errors++;
      end
      if (got.last !== exp_run.last) begin
        $error("run_last: expected %b, got %b", exp_run.last, got.last);
        errors++;
      end
      if (got.hit !== exp_run.hit) begin
        $error("limit_hit: expected %b, got %b", exp_run.hit, got.hit);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        cfg_we_i    = 1'b0;
  logic [0:0]  cfg_index_i = REG_LIMIT_ENABLE;
  logic [31:0] cfg_wdata_i = '0;
  logic        in_valid_i  = 1'b0;
  logic        in_ready_o;
  logic [7:0]  data_byte_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [15:0] sample_value_o;
  logic [16:0] repeat_count_o;
  logic        run_last_o;
  logic        limit_hit_o;

  sample_run_scoreboard sb = new();

  // Pacing state for both sides.
  int unsigned in_count  = 0;
  int unsigned out_count = 0;
  bit          in_idle   = 1'b0;
  bit          out_idle  = 1'b0;
  bit          in_burst  = 1'b0;  // sender offers back to back
  bit          backlog_req = 1'b0; // receiver holds off for a long stretch

  logic_sample_rle_expander_top i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .data_byte_i    (data_byte_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .sample_value_o (sample_value_o),
    .repeat_count_o (repeat_count_o),
    .run_last_o     (run_last_o),
    .limit_hit_o    (limit_hit_o)
  );

  always #1 clk_i = ~clk_i;

  // Sample both handshakes with the values that stood before the edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) sb.absorb_byte(data_byte_i);
      if (out_valid_o && out_ready_i)
        sb.check_run({sample_value_o, repeat_count_o, run_last_o, limit_hit_o});
    end
  end

  // Offer one byte after a random gap; leave valid high once accepted so a
  // back-to-back transaction needs no second assignment in the same step.
  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    if (in_count % 16 == 0) in_idle = ($urandom_range(0, 2) != 0);
    in_count++;
    gap = (in_idle && !in_burst) ? $urandom_range(0, 14) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    data_byte_i <= b;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Chunk layout: stamp, first sample, second sample, all little-endian.
  task automatic send_chunk(input logic [15:0] stamp, input logic [15:0] first,
                            input logic [15:0] second);
    send_byte(stamp[7:0]);
    send_byte(stamp[15:8]);
    send_byte(first[7:0]);
    send_byte(first[15:8]);
    send_byte(second[7:0]);
    send_byte(second[15:8]);
  endtask

  function automatic logic [15:0] pick_stamp(input bit short_runs);
    case ($urandom_range(0, 4))
      0:       return 16'($urandom_range(0, 2));
      1:       return 16'hFFFF;
      default: return short_runs ? 16'($urandom_range(0, 60)) : 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_sample();
    case ($urandom_range(0, 5))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // Write one register, then drop the enable on the following edge.
  task automatic write_reg(input cfg_reg_e idx, input logic [31:0] value);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    sb.mirror_reg(idx, value);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Drop valid, wait for every expected result, then cover the chunk
  // latency for bytes that produce nothing.
  task automatic settle();
    int unsigned guard;
    guard = 0;
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.expected_runs.size() != 0 && guard < 20000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (10) @(posedge clk_i);
  endtask

  // Receiver: random ready gaps, plus one long hold-off on request.
  initial begin
    int unsigned gap;
    @(posedge rst_ni);
    forever begin
      if (out_count % 16 == 0) out_idle = ($urandom_range(0, 2) != 0);
      out_count++;
      gap = out_idle ? $urandom_range(0, 14) : 0;
      if (backlog_req) gap = 300;
      if (gap > 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
        backlog_req = 1'b0;
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  // Stop a hung run.
  initial begin
    #200000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    logic [31:0] final_limit;
    int unsigned n;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: prime, stamp zero and one (no run), then the longest run.
    send_chunk(16'hFFFF, 16'h0000, 16'hFFFF);
    send_chunk(16'h0000, 16'h0000, 16'hA5A5);
    send_chunk(16'h0001, 16'hFFFF, 16'h5A5A);
    send_chunk(16'hFFFF, 16'h00FF, 16'hFF00);
    settle();

    // Limit on with the largest budget; upper enable bits must be ignored.
    write_reg(REG_SAMPLE_LIMIT, 32'hFFFF_FFFF);
    write_reg(REG_LIMIT_ENABLE, 32'hFFFF_FFFF);
    for (n = 0; n < 8; n++) send_chunk(pick_stamp(1'b0), pick_sample(), pick_sample());
    settle();

    // Limit off (bit zero clear) with an empty counter: nothing may stop.
    // Hold the receiver off while the sender streams back to back.
    write_reg(REG_LIMIT_ENABLE, 32'hFFFF_FFFE);
    write_reg(REG_SAMPLE_LIMIT, 32'h0000_0000);
    backlog_req = 1'b1;
    in_burst    = 1'b1;
    for (n = 0; n < 8; n++) begin
      if (n == 5) in_burst = 1'b0;
      send_chunk(pick_stamp(1'b0), pick_sample(), pick_sample());
    end
    settle();

    // Final phase: run the counter down to the stop, sometimes from zero.
    final_limit = ($urandom_range(0, 3) == 0) ? 32'd0 : 32'($urandom_range(1, 400));
    write_reg(REG_SAMPLE_LIMIT, final_limit);
    write_reg(REG_LIMIT_ENABLE, 32'd1);
    for (n = 0; n < 20 && !sb.stopped; n++)
      send_chunk(pick_stamp(1'b1), pick_sample(), pick_sample());
    settle();

    // A reload must not restart a stopped block; these bytes are dropped.
    write_reg(REG_SAMPLE_LIMIT, 32'($urandom));
    for (n = 0; n < 12; n++) send_byte(8'($urandom));
    settle();

    if (sb.expected_runs.size() != 0) begin
      $error("%0d expected results never arrived", sb.expected_runs.size());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
